// ----- rtl/tfo_bh_pkg.sv -----
// Shared types and constants of the fast-open failure tracker.
package tfo_bh_pkg;

    localparam int ENTRIES   = 64;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int KEY_W     = 64;
    localparam int FAIL_W    = 16;
    localparam int TICK_W    = 32;
    localparam int CNT_W     = 7;
    localparam int OP_W      = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 32;
    localparam int IN_DATA_W = 160;
    localparam int IN_USER_W = 4;
    localparam int OUT_W     = 16;

    localparam logic [CFG_IDX_W-1:0] REG_FAIL_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS  = 1'd1;

    localparam logic [FAIL_W-1:0] THRESHOLD_RST = 16'd3;
    localparam logic [TICK_W-1:0] TIMEOUT_RST   = 32'd3600;
    localparam logic [FAIL_W-1:0] FAIL_MAX      = '1;
    localparam logic [CNT_W-1:0]  CNT_MAX       = '1;

    typedef enum logic [OP_W-1:0] {
        OP_RECORD = 3'd0,
        OP_CHECK  = 3'd1,
        OP_CLEAR  = 3'd2,
        OP_SWEEP  = 3'd3,
        OP_FLUSH  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TAIL,
        S_UPDATE,
        S_RESP
    } t_state;

    typedef struct packed {
        logic load;     // capture the input transaction, restart the walk
        logic issue;    // read the next table entry
        logic update;   // apply the final write and form the result
        logic present;  // move the result into the output register
    } t_cmd;

    typedef struct packed {
        logic last_addr;
        logic out_free;
    } t_sts;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [FAIL_W-1:0] fail;
        logic [TICK_W-1:0] last_tick;
    } t_entry;

endpackage

// ----- rtl/tfo_bh_ctrl.sv -----
// Sequencer of the tracker: accept, table walk, update and result hand-off.
module tfo_bh_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  tfo_bh_pkg::t_sts  i_sts,
    output tfo_bh_pkg::t_cmd  o_cmd
);
    import tfo_bh_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.last_addr) n_state = S_TAIL;
            end
            S_TAIL:   n_state = S_UPDATE;
            S_UPDATE: n_state = S_RESP;
            S_RESP: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            S_SCAN:   o_cmd.issue   = 1'b1;
            S_TAIL:   o_cmd         = '0;
            S_UPDATE: o_cmd.update  = 1'b1;
            S_RESP:   o_cmd.present = i_sts.out_free;
            default:  o_cmd         = '0;
        endcase
    end

endmodule

// ----- rtl/tfo_bh_dp.sv -----
// Datapath of the tracker: entry memory, valid bits, walk evaluation, result.
module tfo_bh_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tfo_bh_pkg::t_cmd                    i_cmd,
    output tfo_bh_pkg::t_sts                    o_sts,
    input  logic                                i_cfg_we,
    input  logic [tfo_bh_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tfo_bh_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  logic [tfo_bh_pkg::OP_W-1:0]         i_op,
    input  logic                                i_is_ip4,
    input  logic [tfo_bh_pkg::KEY_W-1:0]        i_addr_hi,
    input  logic [tfo_bh_pkg::KEY_W-1:0]        i_addr_lo,
    input  logic [tfo_bh_pkg::TICK_W-1:0]       i_now,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [tfo_bh_pkg::OUT_W-1:0]        o_m_tdata
);
    import tfo_bh_pkg::*;

    // captured transaction
    t_op               r_op;
    logic [KEY_W-1:0]  r_key;
    logic [TICK_W-1:0] r_now;

    // configuration
    logic [FAIL_W-1:0] r_thr;
    logic [TICK_W-1:0] r_timeout;

    // table
    t_entry             r_mem [ENTRIES];
    logic [ENTRIES-1:0] r_valid;

    // walk
    logic [IDX_W-1:0]  r_addr;
    logic              r_rd_vld;
    logic [IDX_W-1:0]  r_rd_idx;
    t_entry            r_rd_data;
    logic              r_hit;
    logic [IDX_W-1:0]  r_hit_idx;
    logic [FAIL_W-1:0] r_hit_fail;
    logic [TICK_W-1:0] r_hit_tick;
    logic              r_free_found;
    logic [IDX_W-1:0]  r_free_idx;
    logic [CNT_W-1:0]  r_count;

    // result
    logic              r_res_bh;
    logic [CNT_W-1:0]  r_res_freed;
    logic              r_res_full;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data;

    logic              ent_valid;
    logic              key_match;
    logic [TICK_W-1:0] ent_age;
    logic              ent_stale;
    logic              ent_drop;
    logic [KEY_W-1:0]  in_key;
    logic [TICK_W-1:0] hit_age;
    logic              hit_stale;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    t_entry            mem_wdata;
    logic              res_bh;
    logic [CNT_W-1:0]  res_freed;
    logic              res_full;

    assign in_key = i_is_ip4 ? {{(KEY_W-32){1'b0}}, i_addr_lo[31:0]} : (i_addr_hi ^ i_addr_lo);

    // per-entry evaluation of the word read in the previous cycle
    assign ent_valid = r_valid[r_rd_idx];
    assign key_match = ent_valid && (r_rd_data.key == r_key);
    assign ent_age   = r_now - r_rd_data.last_tick;
    assign ent_stale = ent_age > r_timeout;
    always_comb begin
        ent_drop = 1'b0;
        unique case (r_op)
            OP_SWEEP: ent_drop = ent_valid && (r_rd_data.fail == '0) && ent_stale;
            OP_FLUSH: ent_drop = ent_valid;
            default:  ent_drop = 1'b0;
        endcase
    end

    assign hit_age   = r_now - r_hit_tick;
    assign hit_stale = hit_age > r_timeout;

    assign o_sts.last_addr = (r_addr == IDX_W'(ENTRIES - 1));
    assign o_sts.out_free  = !r_out_valid || i_m_tready;

    // final write and result of the transaction
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_hit_idx;
        mem_wdata = '{key: r_key, fail: r_hit_fail, last_tick: r_hit_tick};
        res_bh    = 1'b0;
        res_freed = '0;
        res_full  = 1'b0;
        unique case (r_op)
            OP_RECORD: begin
                if (r_hit) begin
                    mem_we = i_cmd.update;
                    mem_wdata.fail = (r_hit_fail == FAIL_MAX) ? r_hit_fail
                                                              : r_hit_fail + 1'b1;
                    mem_wdata.last_tick = r_now;
                end else if (r_free_found) begin
                    mem_we    = i_cmd.update;
                    mem_waddr = r_free_idx;
                    mem_wdata = '{key: r_key, fail: FAIL_W'(1), last_tick: r_now};
                end else begin
                    res_full = 1'b1;
                end
            end
            OP_CHECK: begin
                if (r_hit) begin
                    if (hit_stale) begin
                        mem_we = i_cmd.update;
                        mem_wdata.fail = '0;
                    end else begin
                        res_bh = r_hit_fail >= r_thr;
                    end
                end
            end
            OP_CLEAR: res_freed = CNT_W'(r_hit);
            OP_SWEEP, OP_FLUSH: res_freed = r_count;
            default: res_bh = 1'b0;
        endcase
    end

    // entry memory: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (i_cmd.issue) r_rd_data <= r_mem[r_addr];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= t_op'(i_op);
            r_key <= in_key;
            r_now <= i_now;
        end
        if (i_cmd.issue) r_rd_idx <= r_addr;
        if (r_rd_vld && key_match && !r_hit) begin
            r_hit_idx  <= r_rd_idx;
            r_hit_fail <= r_rd_data.fail;
            r_hit_tick <= r_rd_data.last_tick;
        end
        if (r_rd_vld && !ent_valid && !r_free_found) r_free_idx <= r_rd_idx;
        if (i_cmd.update) begin
            r_res_bh    <= res_bh;
            r_res_freed <= res_freed;
            r_res_full  <= res_full;
        end
        if (i_cmd.present) r_out_data <= {{(OUT_W-CNT_W-2){1'b0}}, r_res_full, r_res_freed, r_res_bh};
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr        <= THRESHOLD_RST;
            r_timeout    <= TIMEOUT_RST;
            r_valid      <= '0;
            r_addr       <= '0;
            r_rd_vld     <= 1'b0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_FAIL_THRESHOLD: r_thr     <= i_cfg_wdata[FAIL_W-1:0];
                    REG_TIMEOUT_TICKS:  r_timeout <= i_cfg_wdata[TICK_W-1:0];
                    default:            r_thr     <= r_thr;
                endcase
            end
            r_rd_vld <= i_cmd.issue;
            if (i_cmd.load) begin
                r_addr       <= '0;
                r_hit        <= 1'b0;
                r_free_found <= 1'b0;
                r_count      <= '0;
            end else if (i_cmd.issue) begin
                r_addr <= r_addr + 1'b1;
            end
            if (r_rd_vld) begin
                if (key_match) r_hit <= 1'b1;
                if (!ent_valid) r_free_found <= 1'b1;
                if (ent_drop) begin
                    r_valid[r_rd_idx] <= 1'b0;
                    if (r_count != CNT_MAX) r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.update) begin
                if (r_op == OP_RECORD && !r_hit && r_free_found) r_valid[r_free_idx] <= 1'b1;
                if (r_op == OP_CLEAR && r_hit) r_valid[r_hit_idx] <= 1'b0;
            end
            if (i_cmd.present) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    a_full_only_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update && res_full |-> r_op == OP_RECORD && !r_free_found)
        else $error("table_full raised without a full table on record");

    a_alloc_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update && r_op == OP_RECORD && !r_hit && r_free_found
        |=> r_valid[$past(r_free_idx)])
        else $error("allocated entry not marked valid");

    a_clear_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update && r_op == OP_CLEAR && r_hit |=> !r_valid[$past(r_hit_idx)])
        else $error("cleared entry still valid");

    a_result_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |-> !(res_bh && (res_full || res_freed != '0)))
        else $error("more than one result field set");

    a_no_update_mid_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |-> !r_rd_vld && !i_cmd.issue)
        else $error("final write overlaps the table walk");

endmodule

// ----- rtl/tfo_blackhole_tracker_top.sv -----
// Top level of the per-peer fast-open failure tracker.
//
// Channels: the slave stream carries one command per transaction
// (record, check, clear, sweep or flush) with the peer address and the
// current tick; the master stream returns exactly one result transaction
// per command. Registers fail_threshold (index 0) and timeout_ticks
// (index 1) are written through i_cfg_we/i_cfg_idx/i_cfg_wdata; the user
// must write them only while idle, as the block does not enforce it.
// Table walk: every command walks all 64 table entries through
// the single read port of the entry memory, one entry per cycle. The walk
// is followed by the tail, update and result states, and a new command is
// taken only after the last result has moved into the output register.
//
// Reset (synchronous, active low) marks every entry free by clearing the
// valid bits and restores the register defaults; no clearing pass is needed.
// When the receiver stalls, the result holds in the output register; the
// sequencer still takes the next command and walks the table, then holds
// in its result state until the output register frees.
module tfo_blackhole_tracker_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic [tfo_bh_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tfo_bh_pkg::CFG_W-1:0]          i_cfg_wdata,
    // command stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [tfo_bh_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // addr_hi, addr_lo, now_ticks
    input  logic [tfo_bh_pkg::IN_USER_W-1:0]      s_axis_tuser,  // operation, is_ip4
    // result stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [tfo_bh_pkg::OUT_W-1:0]          m_axis_tdata   // blackholed, freed_count,
                                                                 // table_full, zero pad
);
    import tfo_bh_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequence accept, walk, update and hand-off
    tfo_bh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // table storage, per-entry evaluation and result register
    tfo_bh_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_op        (s_axis_tuser[OP_W-1:0]),
        .i_is_ip4    (s_axis_tuser[OP_W]),
        .i_addr_hi   (s_axis_tdata[KEY_W-1:0]),
        .i_addr_lo   (s_axis_tdata[2*KEY_W-1:KEY_W]),
        .i_now       (s_axis_tdata[2*KEY_W+TICK_W-1:2*KEY_W]),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_m_tdata   (m_axis_tdata)
    );

endmodule
